### design/keyed_stock_table_macros.svh
// Assertion macros for the keyed stock table datapath.
// Define NO_ASSERTIONS to compile them out.
`ifndef KEYED_STOCK_TABLE_MACROS_SVH
`define KEYED_STOCK_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define KST_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define KST_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define KST_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### design/kst_pkg.sv
package kst_pkg;

   localparam int OP_W  = 2;
   localparam int KEY_W = 31;
   localparam int ST_W  = 3;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_W-1:0] OP_ORDER  = 2'd2;

   // Status codes.
   localparam logic [ST_W-1:0] ST_OK    = 3'd0;
   localparam logic [ST_W-1:0] ST_DUP   = 3'd1;
   localparam logic [ST_W-1:0] ST_FULL  = 3'd2;
   localparam logic [ST_W-1:0] ST_MISS  = 3'd3;
   localparam logic [ST_W-1:0] ST_SHORT = 3'd4;
   localparam logic [ST_W-1:0] ST_BADQ  = 3'd5;

   // The bucket remainder comes out of a four stage reciprocal multiply.
   localparam int HASH_STEPS = 4;
   localparam int HASH_CNT_W = $clog2(HASH_STEPS);

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] item_id;
      logic [KEY_W-1:0] price;
      logic [KEY_W-1:0] stock;
      logic [KEY_W-1:0] quantity;
   } kst_req_type;

   typedef struct packed {
      logic [ST_W-1:0]  status;
      logic [KEY_W-1:0] found_price;
      logic [KEY_W-1:0] stock_now;
   } kst_rsp_type;

   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] price;
      logic [KEY_W-1:0] stock;
   } kst_way_type;

   typedef struct packed {
      logic clear_we;
      logic load_req;
      logic hash_step;
      logic read_en;
      logic match_en;
      logic update_en;
      logic post_load;
   } kst_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic rsp_free;
   } kst_sts_type;

endpackage

### design/keyed_stock_table.sv
// Each request runs four steps to reduce the key to its bucket (reciprocal
// multiply, shift, multiply back, subtract), then bucket row read, way search,
// update/write-back, and output register load, which waits while a beat is held.
// A new request is accepted only once the previous result is in the output register.
// After reset a clearing pass writes every bucket row, one per cycle,
// and no request is accepted until it finishes.
module keyed_stock_table
   import kst_pkg::*;
#(
   parameter int BUCKETS = 16,
   parameter int WAYS    = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  kst_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output kst_rsp_type rsp_data
);

   kst_cmd_type cmd;
   kst_sts_type sts;

   kst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   kst_datapath #(
      .BUCKETS (BUCKETS),
      .WAYS    (WAYS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### design/kst_mod_unit.sv
module kst_mod_unit
   import kst_pkg::*;
#(
   parameter int BUCKETS = 16
) (
   input  logic                                  clock,
   input  logic                                  load,
   input  logic                                  step,
   input  logic [KEY_W-1:0]                      value,
   output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] remainder
);

   localparam int RW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int SH = KEY_W + $clog2(BUCKETS);
   localparam int PW = 2 * KEY_W + 1;
   localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << SH) + 64'(BUCKETS - 1)) / 64'(BUCKETS);
   localparam logic [KEY_W:0]   RECIP   = (KEY_W + 1)'(RECIP_WIDE);
   localparam logic [KEY_W-1:0] DIVISOR = KEY_W'(BUCKETS);

   logic [KEY_W-1:0] key_ff;
   logic [PW-1:0]    prod_ff, prod_in;
   logic [KEY_W-1:0] quot_ff, quot_in;
   logic [KEY_W-1:0] back_ff, back_in;
   logic [RW-1:0]    rem_ff, rem_in;

   // Every step moves all stages along, so after four steps the remainder
   // belongs to the loaded key: multiply by the rounded-up reciprocal, shift
   // out the quotient, multiply back and subtract. The quotient times the
   // bucket count never exceeds the key, so the back product fits the key width.
   assign prod_in = {{(KEY_W + 1){1'b0}}, key_ff} * {{KEY_W{1'b0}}, RECIP};
   assign quot_in = KEY_W'(prod_ff >> SH);
   assign back_in = quot_ff * DIVISOR;
   assign rem_in  = RW'(key_ff - back_ff);

   always_ff @(posedge clock) begin
      if (load) begin
         key_ff <= value;
      end else if (step) begin
         prod_ff <= prod_in;
         quot_ff <= quot_in;
         back_ff <= back_in;
         rem_ff  <= rem_in;
      end
   end

   assign remainder = rem_ff;

endmodule

### design/kst_datapath.sv
`include "keyed_stock_table_macros.svh"

module kst_datapath
   import kst_pkg::*;
#(
   parameter int BUCKETS = 16,
   parameter int WAYS    = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  kst_cmd_type cmd,
   output kst_sts_type sts,
   input  kst_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output kst_rsp_type rsp_data
);

   localparam int AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

   kst_req_type req_ff;
   logic [AW-1:0] bucket;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;

   kst_way_type [WAYS-1:0] row_mem_ff [BUCKETS];
   kst_way_type [WAYS-1:0] row_ff;
   kst_way_type [WAYS-1:0] new_row;
   kst_way_type [WAYS-1:0] mem_wdata;
   logic [AW-1:0] mem_waddr;
   logic          mem_we;

   logic          hit_in, hit_ff, free_in, free_ff;
   logic [WW-1:0] hit_way_in, hit_way_ff, free_way_in, free_way_ff;
   logic [KEY_W-1:0] sel_price_in, sel_price_ff, sel_stock_in, sel_stock_ff;

   kst_rsp_type res_in, res_ff, rsp_ff;
   logic        upd_we;
   logic        rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
   end

   kst_mod_unit #(
      .BUCKETS (BUCKETS)
   ) u_mod (
      .clock     (clock),
      .load      (cmd.load_req),
      .step      (cmd.hash_step),
      .value     (req_data.item_id),
      .remainder (bucket)
   );

   // Clearing pass over all bucket rows after reset.
   assign clr_cnt_in     = clr_cnt_ff + AW'(1);
   assign sts.clear_last = (clr_cnt_ff == AW'(BUCKETS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_we) begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   assign mem_we    = cmd.clear_we || (cmd.update_en && upd_we);
   assign mem_waddr = cmd.clear_we ? clr_cnt_ff : bucket;
   assign mem_wdata = cmd.clear_we ? '0 : new_row;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (cmd.read_en) begin
         row_ff <= row_mem_ff[bucket];
      end
   end

   // Search the bucket row: the lowest matching way and the lowest free way.
   always_comb begin
      hit_in      = 1'b0;
      free_in     = 1'b0;
      hit_way_in  = '0;
      free_way_in = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (row_ff[w].valid && (row_ff[w].key == req_ff.item_id)) begin
            hit_in     = 1'b1;
            hit_way_in = WW'(w);
         end
         if (!row_ff[w].valid) begin
            free_in     = 1'b1;
            free_way_in = WW'(w);
         end
      end
      sel_price_in = row_ff[hit_way_in].price;
      sel_stock_in = row_ff[hit_way_in].stock;
   end

   always_ff @(posedge clock) begin
      if (cmd.match_en) begin
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         hit_way_ff   <= hit_way_in;
         free_way_ff  <= free_way_in;
         sel_price_ff <= sel_price_in;
         sel_stock_ff <= sel_stock_in;
      end
   end

   always_comb begin
      new_row = row_ff;
      upd_we  = 1'b0;
      res_in  = '{status: ST_OK, found_price: '0, stock_now: '0};
      case (req_ff.op)
         OP_INSERT: begin
            if (hit_ff) begin
               res_in = '{status: ST_DUP, found_price: sel_price_ff,
                          stock_now: sel_stock_ff};
            end else if (free_ff) begin
               upd_we = 1'b1;
               new_row[free_way_ff] = '{valid: 1'b1, key: req_ff.item_id,
                                        price: req_ff.price, stock: req_ff.stock};
               res_in = '{status: ST_OK, found_price: req_ff.price,
                          stock_now: req_ff.stock};
            end else begin
               res_in.status = ST_FULL;
            end
         end
         OP_ORDER: begin
            if (req_ff.quantity == '0) begin
               res_in.status = ST_BADQ;
            end else if (!hit_ff) begin
               res_in.status = ST_MISS;
            end else if (sel_stock_ff < req_ff.quantity) begin
               res_in = '{status: ST_SHORT, found_price: sel_price_ff,
                          stock_now: sel_stock_ff};
            end else begin
               upd_we = 1'b1;
               new_row[hit_way_ff].stock = sel_stock_ff - req_ff.quantity;
               res_in = '{status: ST_OK, found_price: sel_price_ff,
                          stock_now: sel_stock_ff - req_ff.quantity};
            end
         end
         default: begin
            // Lookup, and the unused code behaves the same way.
            if (hit_ff) begin
               res_in = '{status: ST_OK, found_price: sel_price_ff,
                          stock_now: sel_stock_ff};
            end else begin
               res_in.status = ST_MISS;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.update_en) begin
         res_ff <= res_in;
      end
      if (cmd.post_load) begin
         rsp_ff <= res_ff;
      end
   end

   // The output register lets the next request start while a beat waits.
   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = cmd.post_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `KST_ASSERT_IMP(a_post_needs_room, clock, reset, cmd.post_load, !rsp_valid_ff || rsp_ready, "result loaded over an unaccepted beat")
   `KST_ASSERT_NEXT(a_hit_matches_key, clock, reset, cmd.match_en, !hit_ff || (row_ff[hit_way_ff].valid && row_ff[hit_way_ff].key == req_ff.item_id), "recorded hit way does not hold the key")
   `KST_ASSERT_IMP(a_insert_free_way, clock, reset, cmd.update_en && upd_we && req_ff.op == OP_INSERT, !row_ff[free_way_ff].valid && !hit_ff, "insert overwrites a live way")

endmodule

### design/kst_ctrl.sv
module kst_ctrl
   import kst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  kst_sts_type sts,
   output kst_cmd_type cmd
);

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_HASH   = 7'b0000100,
      S_READ   = 7'b0001000,
      S_MATCH  = 7'b0010000,
      S_UPDATE = 7'b0100000,
      S_POST   = 7'b1000000
   } kst_state_type;

   kst_state_type           state_ff, state_in;
   logic [HASH_CNT_W-1:0]   cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_we = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               cnt_in       = '0;
               state_in     = S_HASH;
            end
         end
         S_HASH: begin
            cmd.hash_step = 1'b1;
            cnt_in        = cnt_ff + HASH_CNT_W'(1);
            if (cnt_ff == HASH_CNT_W'(HASH_STEPS - 1)) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.read_en = 1'b1;
            state_in    = S_MATCH;
         end
         S_MATCH: begin
            cmd.match_en = 1'b1;
            state_in     = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update_en = 1'b1;
            state_in      = S_POST;
         end
         S_POST: begin
            if (sts.rsp_free) begin
               cmd.post_load = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

### dv/kst_monitor.sv
// Watches both channels of the keyed stock table, keeps its own copy of the
// record table, and compares every result beat with the oldest prediction.
module kst_monitor
   import kst_pkg::*;
#(
   parameter int BUCKETS = 16,
   parameter int WAYS    = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  kst_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  kst_rsp_type rsp_data,
   output int          mismatch_count,
   output int          rsp_owed
);

   localparam int SLOTS = BUCKETS * WAYS;

   logic             slot_used  [SLOTS];
   logic [KEY_W-1:0] slot_key   [SLOTS];
   logic [KEY_W-1:0] slot_price [SLOTS];
   logic [KEY_W-1:0] slot_stock [SLOTS];

   kst_rsp_type rsp_expected_q[$];

   function automatic int bucket_base(logic [KEY_W-1:0] key);
      return int'(key % BUCKETS) * WAYS;
   endfunction

   function automatic int find_record(logic [KEY_W-1:0] key);
      int base;
      base = bucket_base(key);
      for (int w = 0; w < WAYS; w++) begin
         if (slot_used[base + w] && slot_key[base + w] == key) begin
            return base + w;
         end
      end
      return -1;
   endfunction

   // Applies one request to the shadow table and returns the result it owes.
   function automatic kst_rsp_type apply_to_table(kst_req_type rq);
      kst_rsp_type res;
      int          hit;
      int          base;
      res = '0;
      res.status = ST_OK;
      case (rq.op)
         OP_INSERT: begin
            hit = find_record(rq.item_id);
            if (hit >= 0) begin
               res.status      = ST_DUP;
               res.found_price = slot_price[hit];
               res.stock_now   = slot_stock[hit];
            end else begin
               base = bucket_base(rq.item_id);
               res.status = ST_FULL;
               for (int w = 0; w < WAYS; w++) begin
                  if (res.status == ST_FULL && !slot_used[base + w]) begin
                     slot_used[base + w]  = 1'b1;
                     slot_key[base + w]   = rq.item_id;
                     slot_price[base + w] = rq.price;
                     slot_stock[base + w] = rq.stock;
                     res.status      = ST_OK;
                     res.found_price = rq.price;
                     res.stock_now   = rq.stock;
                  end
               end
            end
         end
         OP_ORDER: begin
            // A zero quantity is refused before the key is even searched.
            if (rq.quantity == '0) begin
               res.status = ST_BADQ;
            end else begin
               hit = find_record(rq.item_id);
               if (hit < 0) begin
                  res.status = ST_MISS;
               end else begin
                  if (slot_stock[hit] < rq.quantity) begin
                     res.status = ST_SHORT;
                  end else begin
                     slot_stock[hit] = slot_stock[hit] - rq.quantity;
                  end
                  res.found_price = slot_price[hit];
                  res.stock_now   = slot_stock[hit];
               end
            end
         end
         default: begin
            // The spare op code behaves as a lookup.
            hit = find_record(rq.item_id);
            if (hit < 0) begin
               res.status = ST_MISS;
            end else begin
               res.found_price = slot_price[hit];
               res.stock_now   = slot_stock[hit];
            end
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      kst_rsp_type want;
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) begin
            slot_used[s] = 1'b0;
         end
         rsp_expected_q.delete();
         mismatch_count = 0;
      end else begin
         // Check the result first: a request taken at this edge cannot own it.
         if (rsp_valid && rsp_ready) begin
            if (rsp_expected_q.size() == 0) begin
               $display("%0t: result beat with nothing pending: %p", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = rsp_expected_q.pop_front();
               if (rsp_data.status != want.status) begin
                  $display("%0t: status expected %0d got %0d",
                           $time, want.status, rsp_data.status);
                  mismatch_count++;
               end
               if (rsp_data.found_price != want.found_price) begin
                  $display("%0t: found_price expected %0d got %0d",
                           $time, want.found_price, rsp_data.found_price);
                  mismatch_count++;
               end
               if (rsp_data.stock_now != want.stock_now) begin
                  $display("%0t: stock_now expected %0d got %0d",
                           $time, want.stock_now, rsp_data.stock_now);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            rsp_expected_q.push_back(apply_to_table(req_data));
         end
      end
      rsp_owed = rsp_expected_q.size();
   end

endmodule

### dv/testbench.sv
module testbench;
   import kst_pkg::*;

   localparam int BUCKETS = 16;
   localparam int WAYS    = 4;
   localparam int RANDOM_ITEMS = 1000;
   localparam int POOL_SIZE    = 48;
   localparam logic [OP_W-1:0]  OP_SPARE = 2'd3;
   localparam logic [KEY_W-1:0] FIELD_MAX = 31'h7fffffff;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   kst_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   kst_rsp_type rsp_data;

   int mismatch_count;
   int rsp_owed;

   // When set, neither side inserts any idle cycles.
   bit calm = 1'b0;
   int stall_left = 0;
   logic [KEY_W-1:0] key_pool [POOL_SIZE];

   keyed_stock_table #(.BUCKETS(BUCKETS), .WAYS(WAYS)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   kst_monitor #(.BUCKETS(BUCKETS), .WAYS(WAYS)) i_monitor (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .mismatch_count(mismatch_count),
      .rsp_owed      (rsp_owed)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

   function automatic logic [KEY_W-1:0] to_field(int unsigned v);
      return v[KEY_W-1:0];
   endfunction

   function automatic logic [KEY_W-1:0] rand_field();
      logic [31:0] r;
      r = $urandom();
      return r[KEY_W-1:0];
   endfunction

   // Mostly back to back, sometimes a short gap, rarely a long pause.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 70) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   task automatic send_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] id,
                               logic [KEY_W-1:0] price, logic [KEY_W-1:0] stock,
                               logic [KEY_W-1:0] qty);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_data.op       <= op;
      req_data.item_id  <= id;
      req_data.price    <= price;
      req_data.stock    <= stock;
      req_data.quantity <= qty;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Result side: ready drops for random stretches.
   initial begin
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   initial begin
      int r;
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] id;
      logic [KEY_W-1:0] stock;
      logic [KEY_W-1:0] qty;

      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = (rand_field() & ~to_field(BUCKETS - 1)) |
                       to_field($urandom_range(0, BUCKETS - 1));
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty table: lookup and order miss, zero quantity is refused.
      send_request(OP_LOOKUP, '0, FIELD_MAX, FIELD_MAX, FIELD_MAX);
      send_request(OP_ORDER, '0, '0, '0, to_field(5));
      send_request(OP_ORDER, '0, '0, '0, '0);
      // Fill bucket zero, try a duplicate, then overflow it.
      send_request(OP_INSERT, '0, '0, '0, FIELD_MAX);
      send_request(OP_INSERT, '0, FIELD_MAX, FIELD_MAX, '0);
      send_request(OP_INSERT, to_field(16), to_field(100), to_field(7), '0);
      send_request(OP_INSERT, to_field(32), to_field(200), to_field(9), '0);
      send_request(OP_INSERT, to_field(48), to_field(300), to_field(11), '0);
      send_request(OP_INSERT, to_field(64), to_field(400), to_field(13), '0);
      send_request(OP_LOOKUP, to_field(48), '0, '0, '0);
      send_request(OP_LOOKUP, to_field(64), '0, '0, '0);
      // Largest key and fields, drained to zero, then one unit short.
      send_request(OP_INSERT, FIELD_MAX, FIELD_MAX, FIELD_MAX, '0);
      send_request(OP_ORDER, FIELD_MAX, '0, '0, FIELD_MAX);
      send_request(OP_ORDER, FIELD_MAX, '0, '0, to_field(1));
      send_request(OP_ORDER, '0, '0, '0, '0);
      send_request(OP_SPARE, FIELD_MAX, '0, '0, '0);
      send_request(OP_SPARE, to_field(3), '0, '0, '0);
      send_request(OP_INSERT, to_field(5), to_field(55), to_field(10), '0);
      send_request(OP_ORDER, to_field(5), '0, '0, to_field(10));
      send_request(OP_ORDER, to_field(5), '0, '0, to_field(1));
      send_request(OP_INSERT, to_field(21), to_field(77), to_field(7), '0);
      send_request(OP_ORDER, to_field(21), '0, '0, to_field(3));
      send_request(OP_ORDER, to_field(21), '0, '0, to_field(5));
      send_request(OP_LOOKUP, to_field(21), '0, '0, '0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            calm = ($urandom_range(0, 3) == 0);
         end
         r = $urandom_range(0, 99);
         if (r < 30) begin
            op = OP_INSERT;
         end else if (r < 60) begin
            op = OP_ORDER;
         end else if (r < 95) begin
            op = OP_LOOKUP;
         end else begin
            op = OP_SPARE;
         end
         // Most keys come from a small pool so that orders and lookups hit.
         if ($urandom_range(0, 9) < 7) begin
            id = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         end else begin
            id = rand_field();
         end
         stock = $urandom_range(0, 1) ? to_field($urandom_range(0, 20)) : rand_field();
         r = $urandom_range(0, 99);
         if (r < 10) begin
            qty = '0;
         end else if (r < 60) begin
            qty = to_field($urandom_range(1, 8));
         end else if (r < 80) begin
            qty = to_field($urandom_range(1, 20));
         end else begin
            qty = rand_field();
         end
         send_request(op, id, rand_field(), stock, qty);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (rsp_owed != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatch_count == 0 && rsp_owed == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+design
design/kst_pkg.sv
design/kst_mod_unit.sv
design/kst_datapath.sv
design/kst_ctrl.sv
design/keyed_stock_table.sv
dv/kst_monitor.sv
dv/testbench.sv
